### src/heat_colormap_blend_defines.svh
// Assertion macros for the heat_colormap_blend checker.
// No dependencies; included by the files that carry assertions.
`ifndef HEAT_COLORMAP_BLEND_DEFINES_SVH
`define HEAT_COLORMAP_BLEND_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define HCB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("heat_colormap_blend: implication check failed");

// Invariant checked on every rising edge outside reset.
`define HCB_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("heat_colormap_blend: invariant check failed");

`endif

### src/hcb_pkg.sv
// Shared types and constants for the heat colormap blend pipeline.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hcb_pkg;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_HEAT_THRESHOLD = 1'b0,
        CFG_BLEND_WEIGHT   = 1'b1
    } cfg_index_e;

    localparam int THRESH_W   = 16;
    localparam int WEIGHT_W   = 9;
    localparam int CFG_DATA_W = 16;
    localparam int HEAT_W     = 24;
    localparam int PIX_W      = 8;
    localparam int COLOR_W    = 9;   // 0..256, 8 fractional bits
    localparam int POS_W      = 11;  // ramp position 0..1024
    localparam int SCALED_W   = 18;  // heat * 1024 / 2^F, up to 255*1024

    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd3917;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd179;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 9'd256;

    // floor(u / 255) as (u * 263173) >> 26, exact for u <= 261120
    localparam int RECIP_W     = 19;
    localparam logic [RECIP_W-1:0] RECIP_MUL = 19'd263173;
    localparam int RECIP_SHIFT = 26;
    localparam int PROD_W      = SCALED_W + RECIP_W;

    // Ramp segment bounds
    localparam logic [POS_W-1:0] SEG_CYAN   = 11'd256;
    localparam logic [POS_W-1:0] SEG_GREEN  = 11'd512;
    localparam logic [POS_W-1:0] SEG_YELLOW = 11'd768;
    localparam logic [POS_W-1:0] SEG_RED    = 11'd1024;
    localparam logic [COLOR_W-1:0] COLOR_ONE = 9'd256;

    // Control carried alongside pipeline stages 1 to 3
    typedef struct packed {
        logic valid;
        logic hot;
    } stage_ctl_t;

endpackage

`default_nettype wire

### src/hcb_blend.sv
// One channel blend: (weight*color*255/256 + (256-weight)*grey)/256, two stages.
// Depends on hcb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hcb_blend (
    input  wire logic                          clk,
    input  wire logic                          hot,
    input  wire logic [hcb_pkg::WEIGHT_W-1:0]  weight,
    input  wire logic [hcb_pkg::COLOR_W-1:0]   color,
    input  wire logic [hcb_pkg::PIX_W-1:0]     gray,
    output logic      [hcb_pkg::PIX_W-1:0]     pixel
);
    import hcb_pkg::*;

    localparam int WC_W  = WEIGHT_W + COLOR_W;
    localparam int GW_W  = WEIGHT_W + PIX_W;
    localparam int NUM_W = WC_W + 8;

    logic [WC_W-1:0]     wc_reg;
    logic [GW_W-1:0]     gw_reg;
    logic [PIX_W-1:0]    gray_reg;
    logic                hot_reg;
    logic [WEIGHT_W-1:0] gray_weight;
    logic [NUM_W-1:0]    num;
    logic [PIX_W-1:0]    pixel_next;
    logic [PIX_W-1:0]    pixel_reg;

    assign gray_weight = WEIGHT_ONE - weight;

    // Stage A: the two products
    always_ff @(posedge clk)
    begin
        wc_reg   <= weight * color;
        gw_reg   <= gray_weight * GW_W'(gray);
        gray_reg <= gray;
        hot_reg  <= hot;
    end

    // Stage B: wc*255 + gw*256, keep bits 23:16; cold pixels pass grey
    always_comb
    begin
        num = (NUM_W'(wc_reg) << 8) - NUM_W'(wc_reg) + (NUM_W'(gw_reg) << 8);
        pixel_next = hot_reg ? num[23:16] : gray_reg;
    end

    always_ff @(posedge clk)
    begin
        pixel_reg <= pixel_next;
    end

    assign pixel = pixel_reg;

endmodule

`default_nettype wire

### src/heat_colormap_blend.sv
// Top level: heat value to jet colormap, blended with background grey, RGB888 out.
// Depends on hcb_pkg and hcb_blend.
//
//  channel   signals                                   handshake
//  -------   ---------------------------------------   ---------------------------
//  input     start, busy, heat_value, background_gray  taken when start && !busy
//  result    done, red, green, blue                    one-cycle strobe on done
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data taken when valid && ready
//
// One item per clock; each result appears on done as its item leaves the sum stage.
// Stages: saturate/compare/scale, reciprocal multiply, ramp, blend products, sum.
// The five-stage pipeline is what sets the latency; busy stays low.
// Reset clears the stage valid bits and loads the register defaults.
// Results cannot be held off, so nothing in the pipeline ever stalls.
`timescale 1ns / 1ps
`default_nettype none

module heat_colormap_blend #(
    parameter int HEAT_FRAC_BITS = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [hcb_pkg::HEAT_W-1:0]        heat_value,
    input  wire logic [hcb_pkg::PIX_W-1:0]         background_gray,
    output logic                                   done,
    output logic      [hcb_pkg::PIX_W-1:0]         red,
    output logic      [hcb_pkg::PIX_W-1:0]         green,
    output logic      [hcb_pkg::PIX_W-1:0]         blue,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire hcb_pkg::cfg_index_e               cfg_index,
    input  wire logic [hcb_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import hcb_pkg::*;

    localparam int SAT_W = 8 + HEAT_FRAC_BITS;
    localparam logic [HEAT_W-1:0] HEAT_FULL = HEAT_W'(255) << HEAT_FRAC_BITS;

    // Configuration registers
    logic [THRESH_W-1:0] threshold_reg;
    logic [WEIGHT_W-1:0] weight_reg;

    // Stage valid/hot bits
    stage_ctl_t s1_reg, s2_reg, s3_reg;
    logic       v4_reg, v5_reg;

    // Payload
    logic [SCALED_W-1:0] scaled_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [PIX_W-1:0]    gray1_reg, gray2_reg, gray3_reg;
    logic [WEIGHT_W-1:0] w1_reg, w2_reg, w3_reg;
    logic [COLOR_W-1:0]  r3_reg, g3_reg, b3_reg;

    logic                accept;
    logic [HEAT_W-1:0]   heat_sat;
    logic [31:0]         heat_x1024;
    stage_ctl_t          s1_next;
    logic [SCALED_W-1:0] scaled_next;
    logic [WEIGHT_W-1:0] w_next;
    logic [POS_W-1:0]    pos;
    logic [COLOR_W-1:0]  r_next, g_next, b_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESH_RESET;
            weight_reg    <= WEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HEAT_THRESHOLD: threshold_reg <= cfg_data[THRESH_W-1:0];
                CFG_BLEND_WEIGHT:   weight_reg    <= cfg_data[WEIGHT_W-1:0];
                default:            ;
            endcase
        end
    end

    // Stage 1: saturate, threshold compare, scale to heat*1024/2^F, clamp weight
    always_comb
    begin
        heat_sat      = (heat_value > HEAT_FULL) ? HEAT_FULL : heat_value;
        s1_next.valid = accept;
        s1_next.hot   = heat_sat > HEAT_W'(threshold_reg);
        heat_x1024    = 32'(heat_sat[SAT_W-1:0]) << 10;
        scaled_next   = SCALED_W'(heat_x1024 >> HEAT_FRAC_BITS);
        w_next        = (weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : weight_reg;
    end

    // Stage 3 ramp: blue, cyan, green, yellow, red
    always_comb
    begin
        pos = prod_reg[RECIP_SHIFT +: POS_W];
        if (pos < SEG_CYAN)
        begin
            r_next = '0;
            g_next = COLOR_W'(pos);
            b_next = COLOR_ONE;
        end
        else if (pos < SEG_GREEN)
        begin
            r_next = '0;
            g_next = COLOR_ONE;
            b_next = COLOR_W'(SEG_GREEN - pos);
        end
        else if (pos < SEG_YELLOW)
        begin
            r_next = COLOR_W'(pos - SEG_GREEN);
            g_next = COLOR_ONE;
            b_next = '0;
        end
        else
        begin
            r_next = COLOR_ONE;
            g_next = COLOR_W'(SEG_RED - pos);
            b_next = '0;
        end
    end

    // Valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            s1_reg <= s1_next;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
            v4_reg <= s3_reg.valid;
            v5_reg <= v4_reg;
        end
    end

    // Payload pipeline, stages 1 to 3
    always_ff @(posedge clk)
    begin
        scaled_reg <= scaled_next;
        gray1_reg  <= background_gray;
        w1_reg     <= w_next;

        prod_reg   <= scaled_reg * RECIP_MUL;
        gray2_reg  <= gray1_reg;
        w2_reg     <= w1_reg;

        r3_reg     <= r_next;
        g3_reg     <= g_next;
        b3_reg     <= b_next;
        gray3_reg  <= gray2_reg;
        w3_reg     <= w2_reg;
    end

    // Stages 4 and 5: per-channel blend
    hcb_blend u_blend_red (
        .clk    (clk),
        .hot    (s3_reg.hot),
        .weight (w3_reg),
        .color  (r3_reg),
        .gray   (gray3_reg),
        .pixel  (red)
    );

    hcb_blend u_blend_green (
        .clk    (clk),
        .hot    (s3_reg.hot),
        .weight (w3_reg),
        .color  (g3_reg),
        .gray   (gray3_reg),
        .pixel  (green)
    );

    hcb_blend u_blend_blue (
        .clk    (clk),
        .hot    (s3_reg.hot),
        .weight (w3_reg),
        .color  (b3_reg),
        .gray   (gray3_reg),
        .pixel  (blue)
    );

    assign done = v5_reg;

endmodule

`default_nettype wire

### src/hcb_checker.sv
// Port-level checks for heat_colormap_blend, bound to the top level.
// Depends on hcb_pkg and heat_colormap_blend_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "heat_colormap_blend_defines.svh"

module hcb_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              start,
    input wire logic                              busy,
    input wire logic [hcb_pkg::HEAT_W-1:0]        heat_value,
    input wire logic [hcb_pkg::PIX_W-1:0]         background_gray,
    input wire logic                              done,
    input wire logic [hcb_pkg::PIX_W-1:0]         red,
    input wire logic [hcb_pkg::PIX_W-1:0]         green,
    input wire logic [hcb_pkg::PIX_W-1:0]         blue
);
    import hcb_pkg::*;

    // Every accepted item gives exactly one result, and no result comes without one
    `HCB_ASSERT_IMPLY(a_result_follows, clk, rst_n, start && !busy, ##5 done)
    `HCB_ASSERT_IMPLY(a_no_spurious, clk, rst_n, !(start && !busy), ##5 !done)

    // Zero heat never exceeds the threshold: grey on all channels
    `HCB_ASSERT_IMPLY(a_cold_gray, clk, rst_n, start && !busy && heat_value == '0,
        ##5 (red == $past(background_gray, 5) && green == red && blue == red))

    // The pipeline never refuses an item
    `HCB_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy)

endmodule

bind heat_colormap_blend hcb_checker u_hcb_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .heat_value      (heat_value),
    .background_gray (background_gray),
    .done            (done),
    .red             (red),
    .green           (green),
    .blue            (blue)
);

`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for heat_colormap_blend: heat and grey pixels in, RGB888 out.
// Depends on hcb_pkg and the heat_colormap_blend RTL; reads no files.
`timescale 1ns / 1ps

module tb_top;
    import hcb_pkg::*;

    localparam int FRAC_BITS = 8;
    localparam int unsigned FULL_SCALE = 255 << FRAC_BITS;
    localparam int unsigned QUARTER = FULL_SCALE / 4;   // heat at each ramp knee
    localparam int PIPE_LATENCY = 5;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASES = 10;
    localparam int ITEMS_PER_PHASE = 120;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pixel_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [HEAT_W-1:0] heat_value;
    logic [PIX_W-1:0] background_gray;
    logic done;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic cfg_valid;
    logic cfg_ready;
    cfg_index_e cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow copies of the block's registers, updated at each write handshake
    logic [THRESH_W-1:0] thresh_setting;
    logic [WEIGHT_W-1:0] weight_setting;

    pixel_t expected_pixels[$];
    int error_count;
    int quiet_cycles;
    bit steady_stream;

    heat_colormap_blend #(
        .HEAT_FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .heat_value(heat_value),
        .background_gray(background_gray),
        .done(done),
        .red(red),
        .green(green),
        .blue(blue),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // One blend channel: weight*colour*255 + (256-weight)*grey*256 as 8.16, truncated
    function automatic logic [PIX_W-1:0] mix_channel(input int unsigned color,
                                                      input int unsigned weight,
                                                      input int unsigned grey);
        int unsigned acc;
        acc = weight * color * 255 + (256 - weight) * grey * 256;
        return PIX_W'(acc >> 16);
    endfunction

    // Expected output pixel for one heat/grey pair under the given settings
    function automatic pixel_t blend_pixel(input logic [HEAT_W-1:0] heat,
                                           input logic [PIX_W-1:0] grey,
                                           input logic [THRESH_W-1:0] thresh,
                                           input logic [WEIGHT_W-1:0] weight_raw);
        int unsigned sat_heat;
        int unsigned weight;
        int unsigned pos;
        int unsigned r;
        int unsigned g;
        int unsigned b;
        pixel_t px;
        sat_heat = (heat > FULL_SCALE) ? FULL_SCALE : heat;
        weight = (weight_raw > 256) ? 256 : weight_raw;
        if (sat_heat <= thresh) begin
            px.red = grey;
            px.green = grey;
            px.blue = grey;
            return px;
        end
        // Ramp position 0..1024, four segments of 256
        pos = (sat_heat * 1024) / FULL_SCALE;
        if (pos < 256) begin
            r = 0; g = pos; b = 256;
        end
        else if (pos < 512) begin
            r = 0; g = 256; b = 512 - pos;
        end
        else if (pos < 768) begin
            r = pos - 512; g = 256; b = 0;
        end
        else begin
            r = 256; g = 1024 - pos; b = 0;
        end
        px.red = mix_channel(r, weight, grey);
        px.green = mix_channel(g, weight, grey);
        px.blue = mix_channel(b, weight, grey);
        return px;
    endfunction

    // Sends one item with a random lead-in gap; entered and left at a falling edge
    task automatic send_pixel(input logic [HEAT_W-1:0] heat, input logic [PIX_W-1:0] grey);
        int gap;
        if ($urandom_range(0, 15) == 0)
            steady_stream = !steady_stream;
        gap = steady_stream ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        heat_value <= heat;
        background_gray <= grey;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_pixels.push_back(blend_pixel(heat, grey, thresh_setting, weight_setting));
        @(negedge clk);
    endtask

    // Stops the input side and waits until every pending pixel has come out
    task automatic drain_pipeline;
        start <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // After a drain, writes threshold then weight back to back on the config channel
    task automatic write_settings(input logic [CFG_DATA_W-1:0] thresh_data,
                                  input logic [CFG_DATA_W-1:0] weight_data);
        drain_pipeline();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_HEAT_THRESHOLD;
        cfg_data <= thresh_data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        thresh_setting = thresh_data[THRESH_W-1:0];
        @(negedge clk);
        cfg_index <= CFG_BLEND_WEIGHT;
        cfg_data <= weight_data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        weight_setting = weight_data[WEIGHT_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Reset settings: threshold edge, every ramp knee, saturation of the heat value
    task automatic test_reset_settings;
        send_pixel(24'd0, 8'd255);
        send_pixel(24'(THRESH_RESET), 8'd128);
        send_pixel(24'(THRESH_RESET) + 24'd1, 8'd0);
        send_pixel(24'(QUARTER - 1), 8'd255);
        send_pixel(24'(QUARTER), 8'd0);
        send_pixel(24'(2 * QUARTER - 1), 8'd77);
        send_pixel(24'(2 * QUARTER), 8'd200);
        send_pixel(24'(3 * QUARTER - 1), 8'd255);
        send_pixel(24'(3 * QUARTER), 8'd0);
        send_pixel(24'(FULL_SCALE), 8'd255);
        send_pixel(24'(FULL_SCALE + 1), 8'd31);
        send_pixel(24'hFFFFFF, 8'd0);
    endtask

    // Register extremes: zero and full weight, weight saturation, threshold at
    // zero and at or above full scale (nothing coloured)
    task automatic test_register_extremes;
        write_settings(16'd0, 16'd0);
        send_pixel(24'd1, 8'd200);
        send_pixel(24'(FULL_SCALE), 8'd0);
        write_settings(16'd0, 16'd256);
        send_pixel(24'd0, 8'd100);
        send_pixel(24'hFFFFFF, 8'd100);
        write_settings(16'(FULL_SCALE), 16'hFFFF);
        send_pixel(24'(FULL_SCALE), 8'd50);
        send_pixel(24'hFFFFFF, 8'd255);
        write_settings(16'hFFFF, 16'd300);
        send_pixel(24'h800000, 8'd9);
        write_settings(16'd1, 16'd257);
        send_pixel(24'd2, 8'd0);
    endtask

    // Random traffic over several settings; heat values cluster at the edges
    task automatic test_random_traffic;
        logic [CFG_DATA_W-1:0] thresh_data;
        logic [CFG_DATA_W-1:0] weight_data;
        logic [PIX_W-1:0] grey;
        int heat;
        for (int phase = 0; phase < PHASES; phase++) begin
            case ($urandom_range(0, 9))
                0: thresh_data = 16'd0;
                1: thresh_data = 16'(FULL_SCALE);
                2: thresh_data = 16'hFFFF;
                default: thresh_data = 16'($urandom_range(0, FULL_SCALE));
            endcase
            case ($urandom_range(0, 9))
                0: weight_data = 16'd0;
                1: weight_data = 16'd256;
                2: weight_data = 16'($urandom);   // upper bits are dropped
                default: weight_data = 16'($urandom_range(0, 256));
            endcase
            write_settings(thresh_data, weight_data);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                case ($urandom_range(0, 7))
                    0: heat = int'($urandom_range(0, 24'hFFFFFF));
                    4: heat = int'(thresh_setting) + int'($urandom_range(0, 4)) - 2;
                    5: heat = int'(QUARTER * $urandom_range(1, 3))
                              + int'($urandom_range(0, 4)) - 2;
                    6: heat = int'(FULL_SCALE) + int'($urandom_range(0, 4)) - 2;
                    7: heat = int'($urandom_range(0, 255));
                    default: heat = int'($urandom_range(0, FULL_SCALE));
                endcase
                if (heat < 0)
                    heat = 0;
                if (heat > 24'hFFFFFF)
                    heat = 24'hFFFFFF;
                case ($urandom_range(0, 7))
                    0: grey = 8'd0;
                    1: grey = 8'd255;
                    default: grey = 8'($urandom);
                endcase
                send_pixel(24'(heat), grey);
            end
        end
    endtask

    // Result checker: every strobe must match the oldest pending pixel
    always @(posedge clk) begin
        pixel_t want;
        if (rst_n && done) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected result: red %0d green %0d blue %0d", red, green, blue);
                error_count++;
            end
            else begin
                want = expected_pixels.pop_front();
                if (red !== want.red) begin
                    $error("red: expected %0d, got %0d", want.red, red);
                    error_count++;
                end
                if (green !== want.green) begin
                    $error("green: expected %0d, got %0d", want.green, green);
                    error_count++;
                end
                if (blue !== want.blue) begin
                    $error("blue: expected %0d, got %0d", want.blue, blue);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: too long without any handshake ends the run
    always @(posedge clk) begin
        if (!rst_n)
            quiet_cycles = 0;
        else if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Main sequence
    initial begin
        rst_n = 1'b0;
        start = 1'b0;
        heat_value = '0;
        background_gray = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_HEAT_THRESHOLD;
        cfg_data = '0;
        thresh_setting = THRESH_RESET;
        weight_setting = WEIGHT_RESET;
        error_count = 0;
        steady_stream = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_settings();
        test_register_extremes();
        test_random_traffic();

        drain_pipeline();
        repeat (2 * PIPE_LATENCY) @(posedge clk);
        if (expected_pixels.size() != 0) begin
            $error("%0d pixels never came out", expected_pixels.size());
            error_count++;
        end
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/hcb_pkg.sv
src/hcb_blend.sv
src/heat_colormap_blend.sv
src/hcb_checker.sv
bench/tb_top.sv
